@@ src/sau_pkg.sv @@
// Shared types and constants for the shape area unit.
// No dependencies; used by every module of the block.
package sau_pkg;

  // Shape opcodes
  typedef enum logic [1:0] {
    SHAPE_RECT    = 2'd0,
    SHAPE_TRI     = 2'd1,
    SHAPE_CIRCLE  = 2'd2,
    SHAPE_UNKNOWN = 2'd3
  } shape_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_UNKNOWN = 2'd2
  } status_t;

  localparam int AREA_BITS = 26;
  localparam int PI_BITS   = 16;
  localparam int PI_FRAC   = 14;
  localparam logic [PI_BITS-1:0] PI_Q14 = 16'd51472;

  // Control tag that travels with each item down the pipeline
  typedef struct packed {
    logic    valid;
    shape_t  kind;
    status_t status;
  } tag_t;

endpackage

@@ src/sau_front.sv @@
// Front end: side checks and sum terms, then the two multiply stages.
// Depends on sau_pkg.
module sau_front import sau_pkg::*; #(
  parameter int SIDE_BITS = 12,
  parameter int PROD_BITS = 56
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [1:0]           in_shape,
  input  logic [SIDE_BITS-1:0] in_side_a,
  input  logic [SIDE_BITS-1:0] in_side_b,
  input  logic [SIDE_BITS-1:0] in_side_c,
  output tag_t                 c_tag,
  output logic [PROD_BITS-1:0] c_val
);

  localparam int W  = SIDE_BITS + 2;
  localparam int MW = (2 * W > PI_BITS) ? 2 * W : PI_BITS;

  // Stage A: sums and validity checks
  logic [W-1:0] a, b, c, s_ab, s_ac, s_bc;
  logic [W-1:0] x1, y1, x2, y2;
  shape_t       kind;
  status_t      status;
  logic         tri_bad;

  always_comb begin
    a    = W'(in_side_a);
    b    = W'(in_side_b);
    c    = W'(in_side_c);
    s_ab = a + b;
    s_ac = a + c;
    s_bc = b + c;
    kind = shape_t'(in_shape);
    tri_bad = (a == '0) || (b == '0) || (c == '0) ||
              (s_ab < c) || (s_ac < b) || (s_bc < a);
    x1 = a;
    y1 = b;
    x2 = s_ac - b;
    y2 = s_ab - c;
    unique case (kind)
      SHAPE_RECT: begin
        status = ((a == '0) || (b == '0)) ? STAT_INVALID : STAT_OK;
      end
      SHAPE_TRI: begin
        status = tri_bad ? STAT_INVALID : STAT_OK;
        x1 = s_ab + c;
        y1 = s_bc - a;
      end
      SHAPE_CIRCLE: begin
        status = (a == '0) ? STAT_INVALID : STAT_OK;
        y1 = a;
      end
      default: status = STAT_UNKNOWN;
    endcase
  end

  tag_t         a_tag_r, b_tag_r, c_tag_r;
  logic [W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [2*W-1:0] m1_r, m2_r;
  logic [PROD_BITS-1:0] prod_r;

  // Stage C operand: second product, pi or one
  logic [MW-1:0] op;
  always_comb begin
    unique case (b_tag_r.kind)
      SHAPE_TRI:    op = MW'(m2_r);
      SHAPE_CIRCLE: op = MW'(PI_Q14);
      default:      op = MW'(1);
    endcase
  end

  // Control: valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.valid <= 1'b0;
      b_tag_r.valid <= 1'b0;
      c_tag_r.valid <= 1'b0;
    end else if (adv) begin
      a_tag_r.valid <= in_valid;
      b_tag_r.valid <= a_tag_r.valid;
      c_tag_r.valid <= b_tag_r.valid;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag_r.kind   <= kind;
      a_tag_r.status <= status;
      x1_r <= x1;
      y1_r <= y1;
      x2_r <= x2;
      y2_r <= y2;
      b_tag_r.kind   <= a_tag_r.kind;
      b_tag_r.status <= a_tag_r.status;
      m1_r <= x1_r * y1_r;
      m2_r <= x2_r * y2_r;
      c_tag_r.kind   <= b_tag_r.kind;
      c_tag_r.status <= b_tag_r.status;
      prod_r <= PROD_BITS'(m1_r) * PROD_BITS'(op);
    end
  end

  assign c_tag = c_tag_r;
  assign c_val = prod_r;

endmodule

@@ src/sau_sqrt_cell.sv @@
// One digit cell of the square-root chain: two radicand bits per cell.
// Depends on sau_pkg. Non-triangle items pass through unchanged.
module sau_sqrt_cell import sau_pkg::*; #(
  parameter int PROD_BITS = 56,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  tag_t                 tag_in,
  input  logic [PROD_BITS-1:0] rem_in,
  input  logic [PROD_BITS-1:0] root_in,
  output tag_t                 tag_out,
  output logic [PROD_BITS-1:0] rem_out,
  output logic [PROD_BITS-1:0] root_out
);

  localparam logic [PROD_BITS-1:0] BIT = PROD_BITS'(1) << (PROD_BITS - 2 - 2 * IDX);

  logic [PROD_BITS:0]   trial;
  logic [PROD_BITS-1:0] rem_nxt, root_nxt;
  tag_t                 tag_r;
  logic [PROD_BITS-1:0] rem_r, root_r;

  // Restoring square-root step
  always_comb begin
    trial    = {1'b0, root_in} + {1'b0, BIT};
    rem_nxt  = rem_in;
    root_nxt = root_in;
    if (tag_in.kind == SHAPE_TRI) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[PROD_BITS-1:0];
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        root_nxt = root_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (adv) begin
      tag_r.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r.kind   <= tag_in.kind;
      tag_r.status <= tag_in.status;
      rem_r        <= rem_nxt;
      root_r       <= root_nxt;
    end
  end

  assign tag_out  = tag_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

@@ src/shape_area_unit.sv @@
// Top level of the shape area unit: front end, square-root cell chain, output stage.
// Depends on sau_pkg, sau_front and sau_sqrt_cell.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_shape, in_side_a/b/c
//  out     | output    | out_valid, out_stall, out_area, out_status
//
// One transfer per cycle in each direction when out is not stalled.
// Pipeline: three front-end stages (sums, then two multiply stages), one sqrt
// cell per result bit, one output register.
// The whole pipeline advances together; in_stall rises only while a result
// waits in the output register and out_stall is high.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
module shape_area_unit import sau_pkg::*; #(
  parameter int SIDE_BITS = 12,
  parameter int FRAC_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_shape,
  input  logic [SIDE_BITS-1:0] in_side_a,
  input  logic [SIDE_BITS-1:0] in_side_b,
  input  logic [SIDE_BITS-1:0] in_side_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AREA_BITS-1:0] out_area,
  output logic [1:0]           out_status
);

  localparam int W     = SIDE_BITS + 2;
  localparam int MW    = (2 * W > PI_BITS) ? 2 * W : PI_BITS;
  localparam int PW    = 2 * W + MW;
  localparam int CELLS = PW / 2;
  localparam int EW    = PW + 8;
  localparam int UP    = 8 - 2 * FRAC_BITS;
  localparam int SH_L  = (UP > 0) ? UP : 0;
  localparam int SH_R  = (UP < 0) ? -UP : 0;
  localparam logic [EW-1:0] LIM = EW'((64'd1 << AREA_BITS) - 64'd1);

  logic adv;
  logic out_valid_r;
  logic [AREA_BITS-1:0] area_r;
  status_t status_r;

  assign in_stall = out_valid_r && out_stall;
  assign adv      = !in_stall;

  // Cell chain boundaries
  tag_t          tag_q  [CELLS+1];
  logic [PW-1:0] rem_q  [CELLS+1];
  logic [PW-1:0] root_q [CELLS+1];

  sau_front #(.SIDE_BITS(SIDE_BITS), .PROD_BITS(PW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_shape  (in_shape),
    .in_side_a (in_side_a),
    .in_side_b (in_side_b),
    .in_side_c (in_side_c),
    .c_tag     (tag_q[0]),
    .c_val     (rem_q[0])
  );
  assign root_q[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    sau_sqrt_cell #(.PROD_BITS(PW), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .tag_in   (tag_q[i]),
      .rem_in   (rem_q[i]),
      .root_in  (root_q[i]),
      .tag_out  (tag_q[i+1]),
      .rem_out  (rem_q[i+1]),
      .root_out (root_q[i+1])
    );
  end

  // Output stage: select, rescale to Q.8, saturate
  tag_t          fin;
  logic [PW-1:0] raw;
  logic [EW-1:0] scaled;
  logic [AREA_BITS-1:0] area_nxt;

  always_comb begin
    fin = tag_q[CELLS];
    unique case (fin.kind)
      SHAPE_TRI:    raw = root_q[CELLS] >> 2;
      SHAPE_CIRCLE: raw = rem_q[CELLS] >> PI_FRAC;
      default:      raw = rem_q[CELLS];
    endcase
    scaled = (EW'(raw) << SH_L) >> SH_R;
    if (fin.status != STAT_OK) begin
      area_nxt = '0;
    end else if (scaled > LIM) begin
      area_nxt = LIM[AREA_BITS-1:0];
    end else begin
      area_nxt = scaled[AREA_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      area_r   <= area_nxt;
      status_r <= fin.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_area   = area_r;
  assign out_status = status_r;

endmodule

@@ src/sau_checker.sv @@
// Port-level checks for shape_area_unit, attached by bind.
// Depends on sau_pkg.
module sau_checker import sau_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [AREA_BITS-1:0] out_area,
  input logic [1:0]           out_status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_area) && $stable(out_status))
    else $error("stalled result changed");

  // Any error status carries a zero area
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_area == '0)
    else $error("nonzero area with error status");

  // Status code of a valid result is always a defined one
  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK) || (out_status == STAT_INVALID) ||
                  (out_status == STAT_UNKNOWN))
    else $error("undefined status code");

  // Input side only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind shape_area_unit sau_checker u_sau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_area   (out_area),
  .out_status (out_status)
);

@@ tb/tb_top.sv @@
// Self-checking bench for shape_area_unit: random and directed shape queries
// against a built-in area predictor. Depends on sau_pkg and the block's RTL.
module tb_top;
  import sau_pkg::*;

  typedef struct packed {
    shape_t      shape;
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] c;
  } query_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    status_t              status;
  } answer_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_shape = '0;
  logic [11:0]          in_side_a = '0;
  logic [11:0]          in_side_b = '0;
  logic [11:0]          in_side_c = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AREA_BITS-1:0] out_area;
  logic [1:0]           out_status;

  query_t  pending_q[$];
  answer_t expected_areas[$];
  int      send_idle_pct = 23;
  int      recv_idle_pct = 61;
  int      errors = 0;
  int      results_seen = 0;
  bit      stim_done = 1'b0;

  shape_area_unit u_dut (.*);

  always #1 clk = ~clk;

  // Integer square root, bit by bit
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      if ((root | (64'd1 << i)) * (root | (64'd1 << i)) <= v) root |= 64'd1 << i;
    end
    return root;
  endfunction

  // Area predictor; areas come out with 8 fraction bits
  function automatic answer_t predict_area(input query_t q);
    answer_t     r;
    logic [63:0] a, b, c, prod;
    a = 64'(q.a); b = 64'(q.b); c = 64'(q.c);
    r.area = '0;
    r.status = STAT_OK;
    case (q.shape)
      SHAPE_RECT: begin
        if (a == 0 || b == 0) r.status = STAT_INVALID;
        else r.area = AREA_BITS'(a * b);
      end
      SHAPE_TRI: begin
        if (a == 0 || b == 0 || c == 0 || a + b < c || a + c < b || b + c < a) begin
          r.status = STAT_INVALID;
        end else begin
          prod = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
          r.area = AREA_BITS'(int_sqrt(prod) >> 2);
        end
      end
      SHAPE_CIRCLE: begin
        if (a == 0) r.status = STAT_INVALID;
        else r.area = AREA_BITS'((a * a * 64'(PI_Q14)) >> PI_FRAC);
      end
      default: r.status = STAT_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic query_t make_query(input shape_t s, input int a, b, c);
    query_t q;
    q.shape = s; q.a = 12'(a); q.b = 12'(b); q.c = 12'(c);
    return q;
  endfunction

  // Random query over all four shapes; most triangles are made well-formed
  function automatic query_t random_query();
    query_t q;
    int     x, y, lo, hi;
    q.shape = shape_t'(2'($urandom_range(0, 3)));
    q.a = 12'($urandom); q.b = 12'($urandom); q.c = 12'($urandom);
    if ($urandom_range(0, 9) == 0) q.a = 12'($urandom_range(1, 15));
    if (q.shape == SHAPE_TRI && $urandom_range(0, 3) != 0) begin
      x = $urandom_range(1, 2047);
      y = $urandom_range(1, 2047);
      lo = (x > y) ? x - y : y - x;
      hi = x + y;
      if (lo == 0) lo = 1;
      if (hi > 4095) hi = 4095;
      q.a = 12'(x); q.b = 12'(y); q.c = 12'($urandom_range(lo, hi));
    end
    return q;
  endfunction

  // Driver: next item goes out once the current one transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_shape  <= pending_q[0].shape;
        in_side_a <= pending_q[0].a;
        in_side_b <= pending_q[0].b;
        in_side_c <= pending_q[0].c;
        expected_areas.push_back(predict_area(pending_q.pop_front()));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, then pick the next stall
  always @(posedge clk) begin
    answer_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_areas.size() == 0) begin
          $error("unexpected result area=%0d status=%0d", out_area, out_status);
          errors++;
        end else begin
          exp_r = expected_areas.pop_front();
          if (out_area !== exp_r.area) begin
            $error("area: expected %0d, got %0d", exp_r.area, out_area);
            errors++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every shape, invalid and degenerate cases
    pending_q.push_back(make_query(SHAPE_RECT, 4095, 4095, 4095));
    pending_q.push_back(make_query(SHAPE_RECT, 1, 1, 0));
    pending_q.push_back(make_query(SHAPE_RECT, 0, 7, 3));
    pending_q.push_back(make_query(SHAPE_RECT, 9, 0, 3));
    pending_q.push_back(make_query(SHAPE_TRI, 4095, 4095, 4095));
    pending_q.push_back(make_query(SHAPE_TRI, 48, 64, 80));
    pending_q.push_back(make_query(SHAPE_TRI, 1, 1, 1));
    pending_q.push_back(make_query(SHAPE_TRI, 10, 20, 30));
    pending_q.push_back(make_query(SHAPE_TRI, 30, 10, 20));
    pending_q.push_back(make_query(SHAPE_TRI, 10, 30, 20));
    pending_q.push_back(make_query(SHAPE_TRI, 10, 20, 31));
    pending_q.push_back(make_query(SHAPE_TRI, 40, 10, 20));
    pending_q.push_back(make_query(SHAPE_TRI, 10, 40, 20));
    pending_q.push_back(make_query(SHAPE_TRI, 0, 5, 5));
    pending_q.push_back(make_query(SHAPE_TRI, 5, 0, 5));
    pending_q.push_back(make_query(SHAPE_TRI, 5, 5, 0));
    pending_q.push_back(make_query(SHAPE_CIRCLE, 4095, 4095, 4095));
    pending_q.push_back(make_query(SHAPE_CIRCLE, 1, 0, 0));
    pending_q.push_back(make_query(SHAPE_CIRCLE, 0, 12, 12));
    pending_q.push_back(make_query(SHAPE_UNKNOWN, 0, 0, 0));
    pending_q.push_back(make_query(SHAPE_UNKNOWN, 4095, 4095, 4095));

    // Random, in three phases of sender and receiver idling
    for (int i = 0; i < 300; i++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);
    send_idle_pct = 61; recv_idle_pct = 23;
    for (int i = 0; i < 300; i++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 300; i++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);

    // Drain, then keep watching for anything spurious
    wait (expected_areas.size() == 0);
    repeat (64) @(posedge clk);
    $display("Checked %0d results: all shapes, invalid, degenerate and unknown cases,",
             results_seen);
    $display("under sender idling, receiver stalls and full rate.");
    if (errors == 0) begin
      $display("[shape_area_unit] OK");
    end else begin
      $display("[shape_area_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("[shape_area_unit] ERROR");
    $finish;
  end
endmodule

@@ shape_area_unit.f @@
src/sau_pkg.sv
src/sau_front.sv
src/sau_sqrt_cell.sv
src/shape_area_unit.sv
src/sau_checker.sv
tb/tb_top.sv
